// ----- hw/rtl/cgm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cgm_pkg;

  // Grid geometry.
  localparam int MAX_SIDE  = 64;
  localparam int SIDE_W    = 7;   // holds MAX_SIDE itself
  localparam int IDX_W     = 6;   // row or column index
  localparam int CNT_W     = 13;  // holds MAX_SIDE * MAX_SIDE

  // Cell size and the constants derived from it.
  localparam int CELL_SIZE = 1000;
  localparam int HALF_CELL = CELL_SIZE / 2;
  localparam int CELL_M1   = CELL_SIZE - 1;

  // Reciprocals for division by the cell size: value * RECIP >> SHIFT.
  localparam int RAD_RECIP = 33555;  // exact for every 15-bit radius plus CELL_M1
  localparam int RAD_SHIFT = 25;
  localparam int POS_RECIP = 16777;  // may fall one short, corrected afterwards
  localparam int POS_SHIFT = 24;

  // Field widths.
  localparam int POS_W     = 24;
  localparam int CIDX_W    = 9;
  localparam int OFF_W     = 15;   // signed cell offset and unclamped index
  localparam int Q_W       = 14;   // quotient magnitude
  localparam int CTR_W     = 16;
  localparam int RAD_W     = 15;

  // Actions.
  localparam logic [1:0] ACT_MARK  = 2'd0;
  localparam logic [1:0] ACT_QPOS  = 2'd1;
  localparam logic [1:0] ACT_QCELL = 2'd2;

  typedef struct packed {
    logic             rd;      // read the row word
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             commit;  // finish the request held in the read registers
    logic             mark;    // set the cell if it is still clear
  } map_req_t;

  typedef struct packed {
    logic             hit;     // cell was marked before this request
    logic [CNT_W-1:0] count;   // marked cells once this request is committed
  } map_stat_t;

  typedef struct packed {
    logic div_en;
    logic fix_en;
  } off_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cgm_offset.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgm_offset import cgm_pkg::*; (
  input  wire logic                    clk,
  input  wire off_ctl_t                ctl,
  input  wire logic signed [POS_W-1:0] pos,
  output logic signed [OFF_W-1:0]      off
);

  logic [POS_W-1:0]    mag;
  logic [37:0]         prod;
  logic [POS_W-1:0]    mag_r;
  logic                neg_r;
  logic [Q_W-1:0]      q0_r;
  logic [POS_W-1:0]    rem;
  logic [Q_W-1:0]      q;
  logic signed [OFF_W-1:0] off_r;
  logic signed [OFF_W-1:0] off_nxt;

  // Negative coordinates round away from zero: ceil((1 - v) / C) = floor((C - v) / C).
  always_comb begin
    if (pos[POS_W-1]) begin
      mag = POS_W'((POS_W+1)'(CELL_SIZE) - {pos[POS_W-1], pos});
    end else begin
      mag = pos;
    end
    prod = 38'(mag) * 38'(POS_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      mag_r <= mag;
      neg_r <= pos[POS_W-1];
      q0_r  <= prod[37:POS_SHIFT];
    end
  end

  // The estimate is at most one below the true quotient.
  always_comb begin
    rem = mag_r - POS_W'(q0_r * POS_W'(CELL_SIZE));
    q   = q0_r + Q_W'(rem >= POS_W'(CELL_SIZE));
    if (neg_r) begin
      off_nxt = -$signed({1'b0, q});
    end else begin
      off_nxt = $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fix_en) begin
      off_r <= off_nxt;
    end
  end

  assign off = off_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cgm_map.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cgm_map import cgm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     clear,
  input  wire map_req_t req,
  output map_stat_t     stat
);

  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rdata_r;
  logic [MAX_SIDE-1:0] row_vld_r;
  logic [IDX_W-1:0]    row_r;
  logic [IDX_W-1:0]    col_r;
  logic [CNT_W-1:0]    count_r;
  logic [MAX_SIDE-1:0] row_word;
  logic [MAX_SIDE-1:0] wdata;
  logic                hit;
  logic                set;

  // A row that has not been written since the last clear reads as all clear.
  always_comb begin
    row_word = row_vld_r[row_r] ? rdata_r : '0;
    hit      = row_word[col_r];
    set      = req.commit && req.mark && !hit;
    wdata    = row_word | (MAX_SIDE'(1) << col_r);
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata_r <= mem[req.row];
      row_r   <= req.row;
      col_r   <= req.col;
    end
    if (set) begin
      mem[row_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      row_vld_r <= '0;
      count_r   <= '0;
    end else if (set) begin
      row_vld_r[row_r] <= 1'b1;
      count_r          <= count_r + CNT_W'(1);
    end
  end

  assign stat.hit   = hit;
  assign stat.count = count_r + CNT_W'(set);

endmodule

`default_nettype wire

// ----- hw/rtl/coverage_grid_marker.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Coverage grid marker: a square map of visited cells around the origin.
// Input channel in_*: one request per item; in_tuser selects the action (mark
// position, query position, query cell by column and row). Configuration
// channel cfg_*: writes the area radius; it is always ready and each write
// sets a new grid side and clears the map and the marked-cell count.
// Result channel out_*: exactly one result per request, carrying the covered
// flag, the in-area flag, the clamped cell, its centre and the counts.
// Sequencing: a request accepted in the idle state passes through the reciprocal
// divide, the remainder correction, the row read and the row write-back of the
// map memory; the write-back step loads its result into the output register
// when that register is free.
// A result waiting in the output register does not block the next request;
// only the write-back step waits for the receiver, and in_tready stays low
// until it has gone through.
// Reset clears the map at once through per-row valid bits (no clearing pass)
// and sets the grid side to the full 64 by 64 grid, as a radius of 32000 would.
module coverage_grid_marker import cgm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pos_x [23:0], pos_y [47:24], cell_col [56:48], cell_row [65:57], zero fill
  input  wire logic [71:0] in_tdata,
  // action [1:0]
  input  wire logic [1:0]  in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // covered [0], in_area [1], res_col [7:2], res_row [13:8], center_x [29:14],
  // center_y [45:30], covered_count [58:46], total_cells [71:59]
  output logic [71:0]      out_tdata,
  // Radius configuration.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [RAD_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0] st_r;
  logic [2:0] st_nxt;

  // Request registers.
  logic [1:0]               act_r;
  logic signed [POS_W-1:0]  x_r;
  logic signed [POS_W-1:0]  y_r;
  logic signed [CIDX_W-1:0] ccol_r;
  logic signed [CIDX_W-1:0] crow_r;

  // Grid side, reloaded on each radius write.
  logic [SIDE_W-1:0] side_r;
  logic [SIDE_W-1:0] side_nxt;
  logic [15:0]       rad_sum;
  logic [31:0]       rad_prod;
  logic [5:0]        rad_cells;
  logic [IDX_W-1:0]  half;

  // Cell resolution.
  off_ctl_t                off_ctl;
  logic signed [OFF_W-1:0] off_x;
  logic signed [OFF_W-1:0] off_y;
  logic signed [OFF_W-1:0] col;
  logic signed [OFF_W-1:0] row;
  logic signed [OFF_W-1:0] side_s;
  logic [IDX_W-1:0]        rc;
  logic [IDX_W-1:0]        rr;
  logic                    in_grid;
  logic [IDX_W-1:0]        rc_r;
  logic [IDX_W-1:0]        rr_r;
  logic                    in_grid_r;

  // Map access.
  map_req_t  map_req;
  map_stat_t map_stat;

  // Result assembly.
  logic                    out_free;
  logic                    fire_wr;
  logic                    covered;
  logic signed [CTR_W-1:0] ctr_x;
  logic signed [CTR_W-1:0] ctr_y;
  logic [CNT_W-1:0]        total;
  logic                    out_tvalid_r;
  logic                    out_tvalid_nxt;
  logic [71:0]             out_tdata_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Grid side from the radius: n = 2 * ceil(radius / CELL_SIZE), held to
  // 2..MAX_SIDE. The reciprocal is exact over the whole 15-bit radius range.
  // ---------------------------------------------------------------------------
  always_comb begin
    rad_sum   = {1'b0, cfg_data} + 16'(CELL_M1);
    rad_prod  = 32'(rad_sum) * 32'(RAD_RECIP);
    rad_cells = rad_prod[30:RAD_SHIFT];
    priority if (rad_cells == 6'd0) begin
      side_nxt = SIDE_W'(2);
    end else if (7'(rad_cells) > 7'(MAX_SIDE / 2)) begin
      side_nxt = SIDE_W'(MAX_SIDE);
    end else begin
      side_nxt = SIDE_W'({rad_cells, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(MAX_SIDE);
    end else if (cfg_valid && cfg_ready) begin
      side_r <= side_nxt;
    end
  end

  assign half = side_r[SIDE_W-1:1];

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign out_free = !out_tvalid_r || out_tready;
  assign fire_wr  = (st_r == ST_WR) && out_free;

  always_comb begin
    unique case (st_r)
      ST_IDLE: st_nxt = (in_tvalid && in_tready) ? ST_DIV : ST_IDLE;
      ST_DIV:  st_nxt = ST_FIX;
      ST_FIX:  st_nxt = ST_RD;
      ST_RD:   st_nxt = ST_WR;
      ST_WR:   st_nxt = out_free ? ST_IDLE : ST_WR;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= in_tuser;
      x_r    <= in_tdata[23:0];
      y_r    <= in_tdata[47:24];
      ccol_r <= in_tdata[56:48];
      crow_r <= in_tdata[65:57];
    end
  end

  // ---------------------------------------------------------------------------
  // World coordinate to cell offset, one divider per axis.
  // ---------------------------------------------------------------------------
  assign off_ctl.div_en = (st_r == ST_DIV);
  assign off_ctl.fix_en = (st_r == ST_FIX);

  cgm_offset u_off_x (
    .clk (clk),
    .ctl (off_ctl),
    .pos (x_r),
    .off (off_x)
  );

  cgm_offset u_off_y (
    .clk (clk),
    .ctl (off_ctl),
    .pos (y_r),
    .off (off_y)
  );

  // ---------------------------------------------------------------------------
  // Unclamped cell, area test and clamping. Action three behaves as a cell
  // query, so bit one of the action alone selects the direct cell indices.
  // ---------------------------------------------------------------------------
  always_comb begin
    side_s = $signed(OFF_W'(side_r));
    if (act_r[1]) begin
      col = {{(OFF_W-CIDX_W){ccol_r[CIDX_W-1]}}, ccol_r};
      row = {{(OFF_W-CIDX_W){crow_r[CIDX_W-1]}}, crow_r};
    end else begin
      col = $signed(OFF_W'(half)) + off_x;
      row = $signed(OFF_W'(half)) + off_y;
    end
    in_grid = !col[OFF_W-1] && (col < side_s) && !row[OFF_W-1] && (row < side_s);
    priority if (col[OFF_W-1]) begin
      rc = '0;
    end else if (col >= side_s) begin
      rc = IDX_W'(side_r - SIDE_W'(1));
    end else begin
      rc = col[IDX_W-1:0];
    end
    priority if (row[OFF_W-1]) begin
      rr = '0;
    end else if (row >= side_s) begin
      rr = IDX_W'(side_r - SIDE_W'(1));
    end else begin
      rr = row[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_RD) begin
      rc_r      <= rc;
      rr_r      <= rr;
      in_grid_r <= in_grid;
    end
  end

  // ---------------------------------------------------------------------------
  // Map memory: the row word is read in the read step and written back in the
  // write step. One request is in flight at a time, so a read never meets a
  // pending write to the same row.
  // ---------------------------------------------------------------------------
  assign map_req.rd     = (st_r == ST_RD);
  assign map_req.row    = rr;
  assign map_req.col    = rc;
  assign map_req.commit = fire_wr;
  assign map_req.mark   = (act_r == ACT_MARK);

  cgm_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (cfg_valid && cfg_ready),
    .req   (map_req),
    .stat  (map_stat)
  );

  // ---------------------------------------------------------------------------
  // Result. A marked cell always reads back as covered; a cell query outside
  // the grid never does, even though its clamped cell may be marked.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (act_r)
      ACT_MARK:  covered = 1'b1;
      ACT_QPOS:  covered = map_stat.hit;
      default:   covered = in_grid_r && map_stat.hit;
    endcase
    ctr_x = $signed(CTR_W'($signed({1'b0, rc_r}) - $signed({1'b0, half})))
            * $signed(CTR_W'(CELL_SIZE)) + $signed(CTR_W'(HALF_CELL));
    ctr_y = $signed(CTR_W'($signed({1'b0, rr_r}) - $signed({1'b0, half})))
            * $signed(CTR_W'(CELL_SIZE)) + $signed(CTR_W'(HALF_CELL));
    total = CNT_W'(side_r) * CNT_W'(side_r);
  end

  always_comb begin
    if (fire_wr) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_wr) begin
      out_tdata_r <= {total, map_stat.count, ctr_y, ctr_x, rr_r, rc_r, in_grid_r, covered};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  // The running count can never pass the number of cells in the grid.
  a_count_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[58:46] <= out_tdata[71:59]))
    else $error("covered count exceeds total cells");

  // An accepted request reaches the memory read step after the two divide steps.
  a_seq_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ##2 (st_r == ST_RD))
    else $error("sequencer skipped a step");

  // A radius write leaves the map empty.
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && st_r == ST_IDLE) |=> (map_stat.count == '0))
    else $error("map not cleared by radius write");
`endif

endmodule

`default_nettype wire
